// ----- sv/rtte_pkg.sv -----
// Package for the RTT timeout estimator: widths, reset values, register
// indexes, and the transaction and stage structs. No dependencies.

package rtte_pkg;

   localparam int TIME_W      = 63;
   localparam int SAMPLE_W    = 32;
   localparam int TIMEOUT_W   = 35;
   localparam int CSR_INDEX_W = 1;

   localparam logic [SAMPLE_W-1:0]  SAMPLE_MIN_RESET = 32'd1000000;
   localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX_RESET = 32'd3000000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 35'd15000000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_LIMIT    = 35'd21474836475;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_MIN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_MAX = 1'b1;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_CHECK  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [TIME_W-1:0] now_time_ns;
      logic [TIME_W-1:0] sent_time_ns;
   } req_type;

   typedef struct packed {
      logic                 expired;
      logic                 sample_taken;
      logic [TIMEOUT_W-1:0] timeout_ns;
   } rsp_type;

   typedef struct packed {
      logic                 mode;
      logic                 negative;
      logic                 elapsed_high;
      logic [TIMEOUT_W-1:0] elapsed_low;
      logic                 in_window;
   } item_type;

endpackage

// ----- sv/rtte_front.sv -----
// Input register of the RTT timeout estimator: elapsed time, window check
// and the sample window registers. Depends on rtte_pkg.

module rtte_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               drain,
   input  rtte_pkg::req_type                  req_data,
   input  logic                               csr_write_en,
   input  logic [rtte_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rtte_pkg::SAMPLE_W-1:0]      csr_write_data,
   output logic                               item_valid,
   output rtte_pkg::item_type                 item
);

   logic                              item_valid_ff, item_valid_in;
   rtte_pkg::item_type                item_ff, item_in;
   logic [rtte_pkg::SAMPLE_W-1:0]     sample_min_ff, sample_min_in;
   logic [rtte_pkg::SAMPLE_W-1:0]     sample_max_ff, sample_max_in;
   logic [rtte_pkg::TIME_W:0]         elapsed;
   logic [rtte_pkg::SAMPLE_W-1:0]     elapsed_short;

   always_comb begin
      elapsed       = {1'b0, req_data.now_time_ns} - {1'b0, req_data.sent_time_ns};
      elapsed_short = elapsed[rtte_pkg::SAMPLE_W-1:0];

      item_in.mode         = req_data.mode;
      item_in.negative     = elapsed[rtte_pkg::TIME_W];
      item_in.elapsed_high = |elapsed[rtte_pkg::TIME_W-1:rtte_pkg::TIMEOUT_W];
      item_in.elapsed_low  = elapsed[rtte_pkg::TIMEOUT_W-1:0];
      item_in.in_window    = !elapsed[rtte_pkg::TIME_W]
                             && !(|elapsed[rtte_pkg::TIME_W-1:rtte_pkg::SAMPLE_W])
                             && (elapsed_short >= sample_min_ff)
                             && (elapsed_short <= sample_max_ff);

      if (accept) begin
         item_valid_in = 1'b1;
      end else if (drain) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end

      sample_min_in = sample_min_ff;
      sample_max_in = sample_max_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            rtte_pkg::CSR_SAMPLE_MIN: begin
               sample_min_in = csr_write_data;
            end
            rtte_pkg::CSR_SAMPLE_MAX: begin
               sample_max_in = csr_write_data;
            end
            default: begin
               sample_min_in = sample_min_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         sample_min_ff <= rtte_pkg::SAMPLE_MIN_RESET;
         sample_max_ff <= rtte_pkg::SAMPLE_MAX_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         sample_min_ff <= sample_min_in;
         sample_max_ff <= sample_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ----- sv/rtte_update.sv -----
// Estimator state and result register of the RTT timeout estimator: smoothed
// RTT, deviation and timeout update, expiry check. Depends on rtte_pkg.

module rtte_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               take,
   input  rtte_pkg::item_type item,
   output logic               rsp_valid,
   output rtte_pkg::rsp_type  rsp_data
);

   localparam int SUM7_W = rtte_pkg::SAMPLE_W + 4;
   localparam int SUM3_W = rtte_pkg::SAMPLE_W + 2;

   logic [rtte_pkg::SAMPLE_W-1:0]  est_ff, est_in;
   logic [rtte_pkg::SAMPLE_W-1:0]  dev_ff, dev_in;
   logic [rtte_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rtte_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [rtte_pkg::SAMPLE_W-1:0]  sample;
   logic [SUM7_W-1:0]              sum7;
   logic [rtte_pkg::SAMPLE_W-1:0]  est_new;
   logic [rtte_pkg::SAMPLE_W-1:0]  diff;
   logic [SUM3_W-1:0]              sum3;
   logic [rtte_pkg::SAMPLE_W-1:0]  dev_new;
   logic [rtte_pkg::TIMEOUT_W-1:0] timeout_new;
   logic                           taken;
   logic                           expired;

   always_comb begin
      sample  = item.elapsed_low[rtte_pkg::SAMPLE_W-1:0];
      sum7    = {1'b0, est_ff, 3'b000} - {4'b0000, est_ff} + {4'b0000, sample};
      est_new = sum7[rtte_pkg::SAMPLE_W+2:3];
      diff    = (sample >= est_new) ? (sample - est_new) : (est_new - sample);
      sum3    = {1'b0, dev_ff, 1'b0} + {2'b00, dev_ff} + {2'b00, diff};
      dev_new = sum3[SUM3_W-1:2];
      timeout_new = {3'b000, est_new} + {1'b0, dev_new, 2'b00};

      taken   = (item.mode == rtte_pkg::MODE_SAMPLE) && item.in_window;
      expired = (item.mode == rtte_pkg::MODE_CHECK) && !item.negative
                && (item.elapsed_high || (item.elapsed_low > timeout_ff));

      est_in     = est_ff;
      dev_in     = dev_ff;
      timeout_in = timeout_ff;
      if (advance && taken) begin
         est_in     = est_new;
         dev_in     = dev_new;
         timeout_in = timeout_new;
      end

      rsp_data_in.expired      = expired;
      rsp_data_in.sample_taken = taken;
      rsp_data_in.timeout_ns   = taken ? timeout_new : timeout_ff;

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= '0;
         dev_ff       <= '0;
         timeout_ff   <= rtte_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         est_ff       <= est_in;
         dev_ff       <= dev_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/rtt_timeout_estimator_top.sv -----
// Top level of the RTT timeout estimator: handshake control around the input
// register (rtte_front) and the state and result register (rtte_update).
// Depends on rtte_pkg.
//
//   port group   direction   payload               transaction
//   req_         in          rtte_pkg::req_type    req_valid && !req_stall
//   rsp_         out         rtte_pkg::rsp_type    rsp_valid && !rsp_stall
//   csr_         in          32-bit write data     csr_write_en
//
// A transaction enters the input register and its result the result register:
// the estimator update runs between the input register and the result register.
// A new transaction is accepted every cycle while req_stall is low; the state
// update is registered with the result, so the next transaction sees it at once.
// Synchronous reset clears both valid bits, the estimate and the deviation, and
// sets timeout and window registers to reset values. A stalled result holds
// the input register, and req_stall rises only when both registers are full.

module rtt_timeout_estimator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rtte_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rtte_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_en,
   input  logic [rtte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rtte_pkg::SAMPLE_W-1:0]    csr_write_data
);

   logic               item_valid;
   rtte_pkg::item_type item;
   logic               out_open;
   logic               advance;
   logic               accept;
   logic               take;

   assign out_open  = !rsp_valid || !rsp_stall;
   assign advance   = item_valid && out_open;
   assign req_stall = item_valid && !out_open;
   assign accept    = req_valid && !req_stall;
   assign take      = rsp_valid && !rsp_stall;

   rtte_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .drain          (advance),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .item_valid     (item_valid),
      .item           (item)
   );

   rtte_update u_update (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .take      (take),
      .item      (item),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/rtte_checker.sv -----
// Port-level assertions for the RTT timeout estimator, bound to
// rtt_timeout_estimator_top. Depends on rtte_pkg.

module rtte_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rtte_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result transaction changed or dropped.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.expired && rsp_data.sample_taken))
      else $error("Result transaction flags both expired and sample taken.");

   a_timeout_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.timeout_ns <= rtte_pkg::TIMEOUT_LIMIT)
      else $error("Timeout exceeds five times the largest sample.");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("Result transaction appeared without an accepted request.");

endmodule

bind rtt_timeout_estimator_top rtte_checker u_checker (.*);
